FILE: rtl/tfn_pkg.sv
// Shared widths, types and helpers for the triangle face normal unit.
package tfn_pkg;

  localparam int COORD_W   = 16;
  localparam int FRAC_BITS = 14;
  localparam int OUT_W     = 16;
  localparam int NORM_BITS = 30;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int PROD_W    = 2 * DIFF_W;
  localparam int MAG_W     = PROD_W + 1;
  localparam int LEN_W     = $clog2(MAG_W + 1);
  localparam int SQ_W      = 2 * NORM_BITS;
  localparam int SUM_W     = SQ_W + 2;
  localparam int ROOT_W    = SUM_W / 2;
  localparam int Q_W       = FRAC_BITS + 1;
  localparam int NUM_W     = NORM_BITS + FRAC_BITS + 1;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [OUT_W-1:0]   comp_t;

  typedef struct packed {
    logic [2:0][NORM_BITS-1:0] m;
    logic [2:0]                neg;
    logic                      degen;
  } side_t;

  function automatic logic [LEN_W-1:0] bit_len(input logic [MAG_W-1:0] v);
    logic [LEN_W-1:0] n;
    n = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (v[i]) n = LEN_W'(i + 1);
    end
    return n;
  endfunction

endpackage

FILE: rtl/tfn_if.sv
// Valid/ready channel interfaces for triangles in and normals out.
interface tfn_in_if;
  import tfn_pkg::*;
  logic   valid;
  logic   ready;
  coord_t first_x, first_y, first_z;
  coord_t second_x, second_y, second_z;
  coord_t third_x, third_y, third_z;
  modport source (output valid, first_x, first_y, first_z, second_x, second_y, second_z,
                  third_x, third_y, third_z, input ready);
  modport sink (input valid, first_x, first_y, first_z, second_x, second_y, second_z,
                third_x, third_y, third_z, output ready);
endinterface

interface tfn_out_if;
  import tfn_pkg::*;
  logic  valid;
  logic  ready;
  comp_t normal_x, normal_y, normal_z;
  logic  degenerate;
  modport source (output valid, normal_x, normal_y, normal_z, degenerate, input ready);
  modport sink (input valid, normal_x, normal_y, normal_z, degenerate, output ready);
endinterface

FILE: rtl/tfn_front.sv
// Edge, cross product, normalising shift and sum of squares pipeline.
module tfn_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   adv,
  input  logic                   in_v,
  input  tfn_pkg::coord_t [8:0]  in_p,
  output logic                   out_v,
  output logic [tfn_pkg::SUM_W-1:0] out_sum,
  output tfn_pkg::side_t         out_side
);
  import tfn_pkg::*;

  logic [7:0] v_r;
  logic signed [DIFF_W-1:0] d_r [6];
  logic signed [PROD_W-1:0] p_r [6];
  logic signed [MAG_W-1:0]  c_r [3];
  logic [MAG_W-1:0]         mag_r [3], mag2_r [3];
  logic [2:0]               neg_r, neg2_r, neg3_r, neg4_r, neg5_r;
  logic [LEN_W-1:0]         len_r;
  logic [NORM_BITS-1:0]     m_r [3], m2_r [3], m3_r [3];
  logic                     dg_r, dg2_r, dg3_r, dg4_r;
  logic [SQ_W-1:0]          sq_r [3];
  logic [SUM_W-1:0]         sum_r;
  logic [MAG_W+NORM_BITS-1:0] sh_nxt [3];
  logic [MAG_W-1:0]         orm;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[6:0], in_v};
    end
  end

  always_comb begin
    orm = mag_r[0] | mag_r[1] | mag_r[2];
    for (int i = 0; i < 3; i++) begin
      if (len_r > LEN_W'(NORM_BITS)) begin
        sh_nxt[i] = (MAG_W+NORM_BITS)'(mag2_r[i]) >> (len_r - LEN_W'(NORM_BITS));
      end else begin
        sh_nxt[i] = (MAG_W+NORM_BITS)'(mag2_r[i]) << (LEN_W'(NORM_BITS) - len_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        d_r[i]   <= DIFF_W'(in_p[3+i]) - DIFF_W'(in_p[i]);
        d_r[3+i] <= DIFF_W'(in_p[6+i]) - DIFF_W'(in_p[i]);
      end
      p_r[0] <= d_r[1] * d_r[5];
      p_r[1] <= d_r[2] * d_r[4];
      p_r[2] <= d_r[2] * d_r[3];
      p_r[3] <= d_r[0] * d_r[5];
      p_r[4] <= d_r[0] * d_r[4];
      p_r[5] <= d_r[1] * d_r[3];
      for (int i = 0; i < 3; i++) begin
        c_r[i] <= MAG_W'(p_r[2*i]) - MAG_W'(p_r[2*i+1]);
        neg_r[i] <= c_r[i][MAG_W-1];
        mag_r[i] <= c_r[i][MAG_W-1] ? MAG_W'(-c_r[i]) : MAG_W'(c_r[i]);
        mag2_r[i] <= mag_r[i];
        m_r[i] <= sh_nxt[i][NORM_BITS-1:0];
        sq_r[i] <= SQ_W'(m_r[i]) * SQ_W'(m_r[i]);
        m2_r[i] <= m_r[i];
        m3_r[i] <= m2_r[i];
      end
      len_r  <= bit_len(orm);
      dg_r   <= (orm == '0);
      dg2_r  <= dg_r;
      dg3_r  <= dg2_r;
      dg4_r  <= dg3_r;
      neg2_r <= neg_r;
      neg3_r <= neg2_r;
      neg4_r <= neg3_r;
      neg5_r <= neg4_r;
      sum_r  <= SUM_W'(sq_r[0]) + SUM_W'(sq_r[1]) + SUM_W'(sq_r[2]);
    end
  end

  assign out_v            = v_r[7];
  assign out_sum          = sum_r;
  assign out_side.m       = {m3_r[2], m3_r[1], m3_r[0]};
  assign out_side.neg     = neg5_r;
  assign out_side.degen   = dg4_r;
endmodule

FILE: rtl/tfn_sqrt.sv
// Bit-per-stage integer square root pipeline.
module tfn_sqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       adv,
  input  logic                       in_v,
  input  logic [tfn_pkg::SUM_W-1:0]  in_sum,
  input  tfn_pkg::side_t             in_side,
  output logic                       out_v,
  output logic [tfn_pkg::ROOT_W-1:0] out_root,
  output tfn_pkg::side_t             out_side
);
  import tfn_pkg::*;

  logic [ROOT_W-1:0] v_r;
  logic [SUM_W-1:0]  rem_r  [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];
  side_t             side_r [ROOT_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[ROOT_W-2:0], in_v};
    end
  end

  for (genvar s = 0; s < ROOT_W; s++) begin : g_st
    localparam int B = ROOT_W - 1 - s;
    logic [SUM_W-1:0]  rem_src;
    logic [ROOT_W-1:0] root_src;
    side_t             side_src;
    logic [SUM_W+1:0]  trial;
    if (s == 0) begin : g_first
      assign rem_src  = in_sum;
      assign root_src = '0;
      assign side_src = in_side;
    end else begin : g_next
      assign rem_src  = rem_r[s-1];
      assign root_src = root_r[s-1];
      assign side_src = side_r[s-1];
    end
    assign trial = ((SUM_W+2)'(root_src) << (B + 1)) + ((SUM_W+2)'(1) << (2 * B));
    always_ff @(posedge clk) begin
      if (adv) begin
        side_r[s] <= side_src;
        if ((SUM_W+2)'(rem_src) >= trial) begin
          rem_r[s]  <= SUM_W'((SUM_W+2)'(rem_src) - trial);
          root_r[s] <= root_src | (ROOT_W'(1) << B);
        end else begin
          rem_r[s]  <= rem_src;
          root_r[s] <= root_src;
        end
      end
    end
  end

  assign out_v    = v_r[ROOT_W-1];
  assign out_root = root_r[ROOT_W-1];
  assign out_side = side_r[ROOT_W-1];
endmodule

FILE: rtl/tfn_div.sv
// Three-lane restoring divider pipeline, one quotient bit per stage.
module tfn_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       adv,
  input  logic                       in_v,
  input  logic [tfn_pkg::ROOT_W-1:0] in_root,
  input  tfn_pkg::side_t             in_side,
  output logic                       out_v,
  output logic [2:0][tfn_pkg::Q_W-1:0] out_q,
  output tfn_pkg::side_t             out_side
);
  import tfn_pkg::*;

  logic [Q_W-1:0]              v_r;
  logic [2:0][NUM_W-1:0]       rem_r  [Q_W];
  logic [2:0][Q_W-1:0]         q_r    [Q_W];
  logic [ROOT_W-1:0]           div_r  [Q_W];
  side_t                       side_r [Q_W];
  logic [ROOT_W-1:0]           rdiv;
  logic [2:0][NUM_W-1:0]       num;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[Q_W-2:0], in_v};
    end
  end

  always_comb begin
    rdiv = (in_root == '0) ? ROOT_W'(1) : in_root;
    for (int i = 0; i < 3; i++) begin
      num[i] = (NUM_W'(in_side.m[i]) << FRAC_BITS) + NUM_W'(rdiv >> 1);
    end
  end

  for (genvar s = 0; s < Q_W; s++) begin : g_st
    localparam int B = Q_W - 1 - s;
    logic [2:0][NUM_W-1:0] rem_src;
    logic [2:0][Q_W-1:0]   q_src;
    logic [ROOT_W-1:0]     div_src;
    side_t                 side_src;
    logic [NUM_W:0]        dsh;
    if (s == 0) begin : g_first
      assign rem_src  = num;
      assign q_src    = '0;
      assign div_src  = rdiv;
      assign side_src = in_side;
    end else begin : g_next
      assign rem_src  = rem_r[s-1];
      assign q_src    = q_r[s-1];
      assign div_src  = div_r[s-1];
      assign side_src = side_r[s-1];
    end
    assign dsh = (NUM_W+1)'(div_src) << B;
    always_ff @(posedge clk) begin
      if (adv) begin
        div_r[s]  <= div_src;
        side_r[s] <= side_src;
        for (int i = 0; i < 3; i++) begin
          if ((NUM_W+1)'(rem_src[i]) >= dsh) begin
            rem_r[s][i] <= NUM_W'((NUM_W+1)'(rem_src[i]) - dsh);
            q_r[s][i]   <= q_src[i] | (Q_W'(1) << B);
          end else begin
            rem_r[s][i] <= rem_src[i];
            q_r[s][i]   <= q_src[i];
          end
        end
      end
    end
  end

  assign out_v    = v_r[Q_W-1];
  assign out_q    = q_r[Q_W-1];
  assign out_side = side_r[Q_W-1];
endmodule

FILE: rtl/triangle_face_normal_unit.sv
// Triangle face normal unit: top level with pipeline control and output register.
// Takes one triangle (three Q8.8 corners) per cycle and returns the negated unit
// normal in Q1.14, plus a flag for a zero cross product (normal then zero).
// The pipeline has eight front stages for edges, cross product, normalising
// shift and sum of squares, 31 square-root stages, 15 divider stages and the
// output register. Throughput is one triangle per cycle; the whole pipeline holds
// while a finished result waits at the output.
module triangle_face_normal_unit (
  input logic        clk,
  input logic        rst_n,
  tfn_in_if.sink     in_tri,
  tfn_out_if.source  out_nrm
);
  import tfn_pkg::*;

  logic              adv;
  logic              f_v, s_v, d_v;
  logic [SUM_W-1:0]  f_sum;
  side_t             f_side, s_side, d_side;
  logic [ROOT_W-1:0] s_root;
  logic [2:0][Q_W-1:0] d_q;
  coord_t [8:0]      pts;
  logic              ov_r;
  comp_t             nx_r, ny_r, nz_r;
  logic              dg_r;
  comp_t [2:0]       n_nxt;

  assign adv = !ov_r || out_nrm.ready;
  assign in_tri.ready = adv;
  assign pts = {in_tri.third_z, in_tri.third_y, in_tri.third_x,
                in_tri.second_z, in_tri.second_y, in_tri.second_x,
                in_tri.first_z, in_tri.first_y, in_tri.first_x};

  tfn_front u_front (.clk, .rst_n, .adv, .in_v(in_tri.valid), .in_p(pts),
                     .out_v(f_v), .out_sum(f_sum), .out_side(f_side));
  tfn_sqrt u_sqrt (.clk, .rst_n, .adv, .in_v(f_v), .in_sum(f_sum), .in_side(f_side),
                   .out_v(s_v), .out_root(s_root), .out_side(s_side));
  tfn_div u_div (.clk, .rst_n, .adv, .in_v(s_v), .in_root(s_root), .in_side(s_side),
                 .out_v(d_v), .out_q(d_q), .out_side(d_side));

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (d_side.degen) begin
        n_nxt[i] = '0;
      end else if (d_side.neg[i]) begin
        n_nxt[i] = comp_t'(d_q[i]);
      end else begin
        n_nxt[i] = -comp_t'(d_q[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (adv) begin
      ov_r <= d_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      nx_r <= n_nxt[0];
      ny_r <= n_nxt[1];
      nz_r <= n_nxt[2];
      dg_r <= d_side.degen;
    end
  end

  assign out_nrm.valid      = ov_r;
  assign out_nrm.normal_x   = nx_r;
  assign out_nrm.normal_y   = ny_r;
  assign out_nrm.normal_z   = nz_r;
  assign out_nrm.degenerate = dg_r;

`ifndef SYNTHESIS
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && dg_r |-> nx_r == '0 && ny_r == '0 && nz_r == '0)
    else $error("degenerate result with non-zero normal");
  a_unit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !dg_r |-> !(nx_r == '0 && ny_r == '0 && nz_r == '0))
    else $error("zero normal without degenerate flag");
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> nx_r <= 16384 && nx_r >= -16384 && ny_r <= 16384 && ny_r >= -16384
             && nz_r <= 16384 && nz_r >= -16384)
    else $error("normal component out of range");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(nx_r) && $stable(dg_r))
    else $error("output register changed while stalled");
`endif
endmodule
